>>> rtl/smm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types and constants for the fp32 square matrix multiplier.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int MaxDim   = 16;
  localparam int IdxW     = $clog2(MaxDim);
  localparam int StoreDep = MaxDim * MaxDim;
  localparam int SizeW    = 5;
  localparam int CountW   = IdxW + 1;
  localparam int GroupLen = 4;

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [SizeW-1:0] SIZE_RESET = SizeW'(MaxDim);

  typedef enum logic {
    FP_MUL,
    FP_ADD
  } fp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_MULW,
    S_ADDG,
    S_ADDGW,
    S_ADDS,
    S_ADDSW,
    S_OUT
  } smm_state_t;

  typedef struct packed {
    logic        start;
    fp_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

endpackage

>>> rtl/smm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/smm_fpu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_fpu
// Shared fp32 multiply / add unit, round to nearest even, three stages.
// ----------------------------------------------------------------------------
module smm_fpu
  import smm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

  // stage 1
  logic               v1;
  logic               sgn1;
  logic [49:0]        w1;
  logic signed [11:0] x1;
  logic               spec1;
  logic [31:0]        specv1;
  // stage 2
  logic               v2;
  logic               sgn2;
  logic [49:0]        w2;
  logic               st2;
  logic [7:0]         e2;
  logic               ovf2;
  logic               zero2;
  logic               spec2;
  logic [31:0]        specv2;

  // unpack
  logic        sa, sb;
  logic [7:0]  ea8, eb8;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;
  logic        nana, nanb, infa, infb, zeroa, zerob;

  always_comb begin
    sa    = req.a[31];
    sb    = req.b[31];
    ea8   = req.a[30:23];
    eb8   = req.b[30:23];
    ma    = {ea8 != 8'd0, req.a[22:0]};
    mb    = {eb8 != 8'd0, req.b[22:0]};
    ea    = (ea8 == 8'd0) ? 8'd1 : ea8;
    eb    = (eb8 == 8'd0) ? 8'd1 : eb8;
    nana  = (ea8 == 8'hFF) && (req.a[22:0] != 23'd0);
    nanb  = (eb8 == 8'hFF) && (req.b[22:0] != 23'd0);
    infa  = (ea8 == 8'hFF) && (req.a[22:0] == 23'd0);
    infb  = (eb8 == 8'hFF) && (req.b[22:0] == 23'd0);
    zeroa = req.a[30:0] == 31'd0;
    zerob = req.b[30:0] == 31'd0;
  end

  // stage 0: multiply or align-and-add
  logic [47:0]        prod;
  logic               a_big;
  logic [23:0]        bigm, smlm;
  logic [7:0]         bige, smle, dexp;
  logic               bigs;
  logic [49:0]        wbig, wsml, wsh;
  logic               shst;
  logic [49:0]        w0;
  logic signed [11:0] x0;
  logic               sgn0;
  logic               spec0;
  logic [31:0]        specv0;

  always_comb begin
    prod   = ma * mb;
    a_big  = req.a[30:0] >= req.b[30:0];
    bigm   = a_big ? ma : mb;
    smlm   = a_big ? mb : ma;
    bige   = a_big ? ea : eb;
    smle   = a_big ? eb : ea;
    bigs   = a_big ? sa : sb;
    dexp   = bige - smle;
    wbig   = {1'b0, bigm, 25'd0};
    wsml   = {1'b0, smlm, 25'd0};
    if (dexp >= 8'd50) begin
      wsh  = '0;
      shst = |wsml;
    end else begin
      wsh  = wsml >> dexp;
      shst = |(wsml & ((50'd1 << dexp) - 50'd1));
    end
    wsh[0] = wsh[0] | shst;
    spec0  = 1'b0;
    specv0 = '0;
    if (req.op == FP_MUL) begin
      w0   = {prod, 2'b00};
      x0   = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
      sgn0 = sa ^ sb;
      if (nana) begin
        spec0 = 1'b1; specv0 = req.a | QUIET_BIT;
      end else if (nanb) begin
        spec0 = 1'b1; specv0 = req.b | QUIET_BIT;
      end else if ((infa && zerob) || (infb && zeroa)) begin
        spec0 = 1'b1; specv0 = DEFAULT_NAN;
      end else if (infa || infb) begin
        spec0 = 1'b1; specv0 = {sa ^ sb, 8'hFF, 23'd0};
      end
    end else begin
      w0   = (sa == sb) ? (wbig + wsh) : (wbig - wsh);
      x0   = $signed({4'd0, bige}) + 12'sd1;
      sgn0 = ((w0 == 50'd0) && (sa != sb)) ? 1'b0 : bigs;
      if (nana) begin
        spec0 = 1'b1; specv0 = req.a | QUIET_BIT;
      end else if (nanb) begin
        spec0 = 1'b1; specv0 = req.b | QUIET_BIT;
      end else if (infa && infb && (sa != sb)) begin
        spec0 = 1'b1; specv0 = DEFAULT_NAN;
      end else if (infa) begin
        spec0 = 1'b1; specv0 = req.a;
      end else if (infb) begin
        spec0 = 1'b1; specv0 = req.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= req.start;
    end
    sgn1   <= sgn0;
    w1     <= w0;
    x1     <= x0;
    spec1  <= spec0;
    specv1 <= specv0;
  end

  // stage 1: normalise
  logic [5:0]         lz;
  logic               lzf;
  logic signed [11:0] xn, rs;
  logic [49:0]        wn;
  logic               stn;
  logic [7:0]         en;
  logic               ovfn;

  always_comb begin
    lz  = 6'd0;
    lzf = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!lzf && w1[i]) begin
        lzf = 1'b1;
        lz  = 6'(49 - i);
      end
    end
    xn   = x1 - $signed({6'd0, lz});
    rs   = 12'sd1 - x1;
    stn  = 1'b0;
    ovfn = xn >= 12'sd255;
    if (xn >= 12'sd1) begin
      wn = w1 << lz;
      en = xn[7:0];
    end else if (x1 >= 12'sd1) begin
      wn = w1 << (x1 - 12'sd1);
      en = 8'd0;
    end else if (rs >= 12'sd50) begin
      wn  = '0;
      stn = |w1;
      en  = 8'd0;
    end else begin
      wn  = w1 >> rs;
      stn = |(w1 & ((50'd1 << rs) - 50'd1));
      en  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sgn2   <= sgn1;
    w2     <= wn;
    st2    <= stn;
    e2     <= en;
    ovf2   <= ovfn;
    zero2  <= !lzf;
    spec2  <= spec1;
    specv2 <= specv1;
  end

  // stage 2: round and pack
  logic [30:0] packed_v;
  logic        rnd_up;
  logic [31:0] res;

  always_comb begin
    packed_v = {e2, w2[48:26]};
    rnd_up   = w2[25] && ((|w2[24:0]) || st2 || w2[26]);
    if (spec2) begin
      res = specv2;
    end else if (zero2) begin
      res = {sgn2, 31'd0};
    end else if (ovf2) begin
      res = {sgn2, 8'hFF, 23'd0};
    end else begin
      res = {sgn2, packed_v + {30'd0, rnd_up}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= v2;
    end
    rsp.result <= res;
  end

endmodule

>>> rtl/square_matrix_multiply_fp32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_matrix_multiply_fp32
// C = A * B for fp32 square matrices up to 16x16, one C element per request.
// Loads are taken while idle and may follow back to back. A compute beat runs
// its products through the one shared three-stage fp unit: the products of
// each group of four are summed and the group sum is added to the running
// sum; each leftover product is added on its own. No beat is taken until
// its result has left. Out-of-range requests answer in the cycle after
// acceptance. Reset is synchronous: size returns to 16, stores are not cleared.
// ----------------------------------------------------------------------------
module square_matrix_multiply_fp32
  import smm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // product_element
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  smm_state_t state, state_next;

  logic [SizeW-1:0]  matrix_size;
  logic [SizeW-1:0]  n;
  logic [IdxW-1:0]   row_q, col_q;
  logic [CountW-1:0] k;
  logic [1:0]        t;
  logic              grp;
  logic [31:0]       sum, g, p, prod;

  logic [IdxW-1:0] in_row, in_col;
  logic            in_range, accept;
  logic            a_we, b_we;
  logic [2*IdxW-1:0] waddr, a_raddr, b_raddr;
  logic [31:0]     a_rdata, b_rdata;
  fpu_req_t        fpu_req;
  fpu_rsp_t        fpu_rsp;

  assign in_row   = s_tdata[3:0];
  assign in_col   = s_tdata[7:4];
  assign n        = (matrix_size > SizeW'(MaxDim)) ? SizeW'(MaxDim) : matrix_size;
  assign in_range = ({1'b0, in_row} < n) && ({1'b0, in_col} < n);
  assign accept   = s_tvalid && s_tready;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {{(32-SizeW){1'b0}}, matrix_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      matrix_size <= pwdata[SizeW-1:0];
    end
  end

  // stores
  assign waddr   = {in_row, in_col};
  assign a_we    = accept && (s_tuser == CMD_LOAD_A);
  assign b_we    = accept && (s_tuser == CMD_LOAD_B);
  assign a_raddr = {row_q, k[IdxW-1:0]};
  assign b_raddr = {k[IdxW-1:0], col_q};

  smm_ram #(.WIDTH(32), .DEPTH(StoreDep)) u_left (
    .clk(clk), .we(a_we), .waddr(waddr), .wdata(s_tdata[39:8]),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  smm_ram #(.WIDTH(32), .DEPTH(StoreDep)) u_right (
    .clk(clk), .we(b_we), .waddr(waddr), .wdata(s_tdata[39:8]),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  smm_fpu u_fpu (
    .clk(clk), .rst(rst), .req(fpu_req), .rsp(fpu_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && (s_tuser == CMD_COMPUTE)) begin
          state_next = in_range ? S_RD : S_OUT;
        end
      end
      S_RD:   state_next = S_MUL;
      S_MUL:  state_next = S_MULW;
      S_MULW: begin
        if (fpu_rsp.done) begin
          if (grp && (t == 2'd0)) begin
            state_next = S_RD;
          end else if (grp) begin
            state_next = S_ADDG;
          end else begin
            state_next = S_ADDS;
          end
        end
      end
      S_ADDG:  state_next = S_ADDGW;
      S_ADDGW: begin
        if (fpu_rsp.done) begin
          state_next = (t == 2'(GroupLen - 1)) ? S_ADDS : S_RD;
        end
      end
      S_ADDS:  state_next = S_ADDSW;
      S_ADDSW: begin
        if (fpu_rsp.done) begin
          state_next = ((k + 1'b1) == CountW'(n)) ? S_OUT : S_RD;
        end
      end
      S_OUT: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    fpu_req.start = 1'b0;
    fpu_req.op    = FP_ADD;
    fpu_req.a     = sum;
    fpu_req.b     = grp ? g : p;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_MUL: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = FP_MUL;
        fpu_req.a     = a_rdata;
        fpu_req.b     = b_rdata;
      end
      S_ADDG: begin
        fpu_req.start = 1'b1;
        fpu_req.a     = g;
        fpu_req.b     = p;
      end
      S_ADDS:  fpu_req.start = 1'b1;
      S_OUT:   m_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_tdata = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= '0;
      t   <= '0;
      grp <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (s_tuser == CMD_COMPUTE)) begin
            k <= '0;
            t <= '0;
          end
        end
        S_RD: begin
          if (t == 2'd0) begin
            grp <= ({1'b0, k} + (CountW + 1)'(GroupLen)) <= (CountW + 1)'(n);
          end
        end
        S_MULW: begin
          if (fpu_rsp.done && grp && (t == 2'd0)) begin
            k <= k + 1'b1;
            t <= 2'd1;
          end
        end
        S_ADDGW: begin
          if (fpu_rsp.done && (t != 2'(GroupLen - 1))) begin
            k <= k + 1'b1;
            t <= t + 1'b1;
          end
        end
        S_ADDSW: begin
          if (fpu_rsp.done) begin
            k <= k + 1'b1;
            t <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && (s_tuser == CMD_COMPUTE)) begin
      row_q <= in_row;
      col_q <= in_col;
      sum   <= 32'd0;
      prod  <= 32'd0;
    end
    if (state == S_MULW && fpu_rsp.done) begin
      p <= fpu_rsp.result;
      if (grp && (t == 2'd0)) begin
        g <= fpu_rsp.result;
      end
    end
    if (state == S_ADDGW && fpu_rsp.done) begin
      g <= fpu_rsp.result;
    end
    if (state == S_ADDSW && fpu_rsp.done) begin
      sum  <= fpu_rsp.result;
      prod <= fpu_rsp.result;
    end
  end

  // checks
  a_fpu_done_expected: assert property (@(posedge clk) disable iff (rst)
    fpu_rsp.done |-> (state == S_MULW || state == S_ADDGW || state == S_ADDSW))
    else $error("fp result with no operation pending");

  a_rem_no_group_pos: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_OUT && state != S_RD && !grp) |-> (t == 2'd0))
    else $error("group position set outside a group");

  a_k_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> ({1'b0, k} < (CountW + 1)'(n)))
    else $error("product index beyond size");

  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == CMD_COMPUTE) |=> (state == S_RD || state == S_OUT))
    else $error("compute beat not started");

endmodule

>>> test/tb_square_matrix_multiply_fp32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_matrix_multiply_fp32
// Self-checking bench for the fp32 square matrix multiplier. Rows 0, 1, 14 and
// 15 of A and the same columns of B are filled first; in-range computes only
// use those rows and columns. Directed and random load/compute beats then run
// under several matrix sizes, with random stalls on both streams. Expected C
// elements come from a bit-accurate fp32 model with grouped summation.
// ----------------------------------------------------------------------------
module tb_square_matrix_multiply_fp32;
  import smm_pkg::*;

  localparam logic [1:0] CmdUnused     = 2'd3;
  localparam logic [2:0] RegMatrixSize = 3'd0;
  localparam logic [31:0] FpPosZero = 32'h0000_0000;
  localparam logic [31:0] FpNegZero = 32'h8000_0000;
  localparam logic [31:0] FpPosInf  = 32'h7f80_0000;
  localparam logic [31:0] FpNegInf  = 32'hff80_0000;
  localparam logic [31:0] FpQNan    = 32'h7fc0_0000;
  localparam logic [31:0] FpMaxNorm = 32'h7f7f_ffff;
  localparam logic [31:0] FpMinSub  = 32'h0000_0001;
  localparam logic [31:0] FpOne     = 32'h3f80_0000;
  localparam int DrainCycles = 200;
  localparam int FillCount   = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // row[3:0], col[7:4], value[39:8]
  logic [1:0]  s_tuser = '0;   // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // product_element
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] a_store [StoreDep];
  logic [31:0] b_store [StoreDep];
  logic [SizeW-1:0] cur_size;
  logic [31:0] c_expected [$];
  int errors = 0;
  int n_results = 0;
  int n_beats = 0;
  bit idle_on = 1'b1;

  square_matrix_multiply_fp32 i_dut (.*);

  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic real fp32_to_real(input logic [31:0] f);
    logic [63:0] d;
    real r;
    d = '0;
    d[63] = f[31];
    if (f[30:23] == 8'hff) begin
      d[62:52] = 11'h7ff;
      d[51:29] = f[22:0];
      return $bitstoreal(d);
    end
    if (f[30:23] == 0) begin
      r = real'(f[22:0]) * (2.0 ** -149);
      return f[31] ? -r : r;
    end
    d[62:52] = 11'(int'(f[30:23]) - 127 + 1023);
    d[51:29] = f[22:0];
    return $bitstoreal(d);
  endfunction

  // Round a double to fp32, nearest even; exact for one mul or add of fp32s.
  function automatic logic [31:0] real_to_fp32(input real r);
    logic [63:0] d, sig, kept, rem, half;
    int e, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7ff)
      return (d[51:0] != 0) ? FpQNan : {d[63], 31'h7f80_0000};
    if (d[62:52] == 0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return {d[63], 31'h7f80_0000};
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh >= 64) return {d[63], 31'd0};
    kept = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    if (e < -126) return {d[63], kept[30:0]};
    if (kept[24]) begin
      kept = kept >> 1;
      e = e + 1;
      if (e > 127) return {d[63], 31'h7f80_0000};
    end
    return {d[63], 8'(e + 127), kept[22:0]};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] x, input logic [31:0] y);
    return real_to_fp32(fp32_to_real(x) * fp32_to_real(y));
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] x, input logic [31:0] y);
    return real_to_fp32(fp32_to_real(x) + fp32_to_real(y));
  endfunction

  function automatic logic [31:0] c_element(input int r, input int c);
    int n, k, t;
    logic [31:0] acc, grp;
    n = (cur_size > MaxDim) ? MaxDim : int'(cur_size);
    if (r >= n || c >= n) return FpPosZero;
    acc = FpPosZero;
    k = 0;
    while (k + GroupLen <= n) begin
      grp = fmul(a_store[r*MaxDim + k], b_store[k*MaxDim + c]);
      for (t = 1; t < GroupLen; t++)
        grp = fadd(grp, fmul(a_store[r*MaxDim + k + t], b_store[(k + t)*MaxDim + c]));
      acc = fadd(acc, grp);
      k += GroupLen;
    end
    for (; k < n; k++)
      acc = fadd(acc, fmul(a_store[r*MaxDim + k], b_store[k*MaxDim + c]));
    return acc;
  endfunction

  // filled rows of A and columns of B: 0, 1, 14, 15
  function automatic int fill_idx(input int i);
    return (i < 2) ? i : i + 12;
  endfunction

  function automatic int pick_idx(input int lim);
    int idx;
    do begin
      idx = fill_idx($urandom_range(0, FillCount - 1));
    end while (idx >= lim);
    return idx;
  endfunction

  function automatic logic [31:0] rand_fp32();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 7))
          0: return FpNegZero;
          1: return FpPosInf;
          2: return FpNegInf;
          3: return FpQNan;
          4: return FpMaxNorm;
          5: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
          6: return FpMinSub;
          default: return FpPosZero;
        endcase
      end
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 136)),
                       23'($urandom)};
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] cmd, input int r, input int c,
                           input logic [31:0] v);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {v, 4'(c), 4'(r)};
    do @(posedge clk); while (!s_tready);
    n_beats++;
    case (cmd)
      CMD_LOAD_A: a_store[r*MaxDim + c] = v;
      CMD_LOAD_B: b_store[r*MaxDim + c] = v;
      CMD_COMPUTE: c_expected.push_back(c_element(r, c));
      default: ;
    endcase
  endtask

  task automatic sender_gap();
    int g;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 16);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (c_expected.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_size(input logic [SizeW-1:0] sz);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegMatrixSize;
    pwdata <= 32'(sz);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_size = sz;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always begin
    if (idle_on && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end else begin
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (c_expected.size() == 0) begin
        $error("product_element: none expected, actual %h", m_tdata);
        errors++;
      end else begin
        if (m_tdata != c_expected[0] &&
            !(c_expected[0][30:23] == 8'hff && c_expected[0][22:0] != 0 &&
              m_tdata[30:23] == 8'hff && m_tdata[22:0] != 0)) begin
          $error("product_element: expected %h actual %h", c_expected[0], m_tdata);
          errors++;
        end
        void'(c_expected.pop_front());
      end
    end
  end

  task automatic test_fill();
    int i, j, f;
    for (i = 0; i < FillCount; i++) begin
      f = fill_idx(i);
      for (j = 0; j < MaxDim; j++) begin
        send_beat(CMD_LOAD_A, f, j, rand_fp32());
        send_beat(CMD_LOAD_B, j, f, rand_fp32());
        sender_gap();
      end
    end
  endtask

  task automatic test_directed();
    send_beat(CMD_LOAD_A, 0, 0, FpOne);
    send_beat(CMD_LOAD_B, 15, 15, 32'hffff_ffff);
    send_beat(CMD_LOAD_A, 15, 0, FpMaxNorm);
    send_beat(CMD_LOAD_B, 0, 15, FpPosInf);
    send_beat(CMD_COMPUTE, 0, 0, 32'hffff_ffff);
    send_beat(CMD_COMPUTE, 15, 15, FpPosZero);
    send_beat(CMD_COMPUTE, 15, 0, FpPosZero);
    send_beat(CMD_COMPUTE, 0, 15, FpPosZero);
    send_beat(CmdUnused, 3, 3, 32'hffff_ffff);
    send_beat(CMD_COMPUTE, 1, 1, FpPosZero);
    write_size(5'd4);
    send_beat(CMD_LOAD_A, 14, 14, FpNegZero);
    send_beat(CMD_COMPUTE, 1, 1, FpPosZero);
    send_beat(CMD_COMPUTE, 4, 0, FpPosZero);
    send_beat(CMD_COMPUTE, 0, 15, FpPosZero);
    write_size(5'd0);
    send_beat(CMD_COMPUTE, 0, 0, FpPosZero);
    write_size(5'd31);
    send_beat(CMD_COMPUTE, 14, 14, FpPosZero);
    send_beat(CMD_COMPUTE, 15, 15, FpPosZero);
  endtask

  task automatic random_phase(input logic [SizeW-1:0] sz, input int count);
    int i, lim, sel;
    write_size(sz);
    lim = (sz > MaxDim) ? MaxDim : int'(sz);
    for (i = 0; i < count; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 9)
        send_beat(sel[0] ? CMD_LOAD_B : CMD_LOAD_A, $urandom_range(0, 15),
                  $urandom_range(0, 15), rand_fp32());
      else if (sel < 18 && lim > 0)
        send_beat(CMD_COMPUTE, pick_idx(lim), pick_idx(lim), $urandom);
      else if (sel < 19 && lim < MaxDim)
        send_beat(CMD_COMPUTE, $urandom_range(lim, 15), $urandom_range(0, 15), $urandom);
      else
        send_beat(CmdUnused, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      sender_gap();
    end
  endtask

  task automatic test_sizes();
    random_phase(5'd16, 40);
    random_phase(5'd1, 30);
    random_phase(5'd5, 30);
    random_phase(5'd4, 30);
    random_phase(5'd0, 15);
    random_phase(5'd8, 30);
    random_phase(5'd31, 30);
    random_phase(5'd13, 30);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    random_phase(5'd16, 40);
    random_phase(5'd7, 30);
  endtask

  initial begin
    cur_size = SIZE_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_fill();
    test_directed();
    test_sizes();
    test_no_idle();
    drain();
    $display("Covered %0d input beats and %0d C elements over sizes 0 to 31,",
             n_beats, n_results);
    $display("with special fp32 operands and random stalls on both streams.");
    if (errors == 0 && c_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
